FILE: sv/waveform_peak_finder_core_assert.svh
// Assertion macros used by the peak finder's top-level RTL file.
`ifndef WAVEFORM_PEAK_FINDER_CORE_ASSERT_SVH
`define WAVEFORM_PEAK_FINDER_CORE_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define WPF_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("peak finder check failed in the same cycle");

// The condition holds in the cycle after the trigger.
`define WPF_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("peak finder check failed in the following cycle");

`endif

FILE: sv/wpf_pkg.sv
// Package with the peak finder's constants, sign codes and record types.
`default_nettype none

package wpf_pkg;

   localparam int MAX_PEAKS   = 16;
   localparam int MAX_SAMPLES = 1024;

   localparam int SAMPLE_W       = 16;
   localparam int HEIGHT_W       = 15;
   localparam int POSITION_W     = 10;
   localparam int PEAK_NUMBER_W  = 4;
   localparam int LEVEL_W        = 17;
   localparam int SLOT_W         = $clog2(MAX_PEAKS);
   localparam int SAMPLE_INDEX_W = $clog2(MAX_SAMPLES);

   localparam logic [LEVEL_W-1:0] VALLEY_SENTINEL = LEVEL_W'(65535);

   localparam logic [1:0] SIGN_POS  = 2'd0;
   localparam logic [1:0] SIGN_NEG  = 2'd1;
   localparam logic [1:0] SIGN_ZERO = 2'd2;

   localparam int PEAK_Q_PTR_W = $clog2(MAX_PEAKS);
   localparam int PEAK_Q_DEPTH = 1 << PEAK_Q_PTR_W;
   localparam int RUN_Q_PTR_W  = 2;
   localparam int RUN_Q_DEPTH  = 1 << RUN_Q_PTR_W;

   typedef struct packed {
      logic [POSITION_W-1:0] position;
      logic [HEIGHT_W-1:0]   height;
   } peak_rec_type;

   typedef struct packed {
      peak_rec_type      last_peak;
      logic [SLOT_W-1:0] last_slot;
      logic              found;
      logic              overflow;
   } run_rec_type;

   typedef struct packed {
      logic         peak_push;
      peak_rec_type peak;
      logic         run_push;
      run_rec_type  run;
   } front_push_type;

   typedef struct packed {
      logic peak_pop;
      logic run_pop;
   } back_pop_type;

   typedef struct packed {
      logic         peak_valid;
      peak_rec_type peak;
      logic         run_valid;
      run_rec_type  run;
   } queue_head_type;

endpackage

`default_nettype wire

FILE: sv/wpf_front.sv
// Front end: takes samples, tracks peaks and valleys, and queues finished peaks and runs.
`default_nettype none

module wpf_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic signed [wpf_pkg::SAMPLE_W-1:0] sample_value,
   input  logic                                last_sample,
   input  logic                                q_full,
   output wpf_pkg::front_push_type             push_bus
);
   import wpf_pkg::*;

   logic [SAMPLE_INDEX_W-1:0] index_ff, index_in;
   logic [LEVEL_W-1:0]        ref_ff, ref_in;
   logic [1:0]                sign_ff, sign_in;
   logic [LEVEL_W-1:0]        valley_ff, valley_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic                      ovf_ff, ovf_in;
   logic [HEIGHT_W-1:0]       cur_h_ff, cur_h_in;
   logic [POSITION_W-1:0]     cur_pos_ff, cur_pos_in;

   logic                  accept;
   logic                  positive;
   logic [HEIGHT_W-1:0]   v;
   logic [LEVEL_W-1:0]    v_level;
   logic [LEVEL_W:0]      grad;
   logic                  rising;
   logic                  level_eq;
   logic [1:0]            sign_now;
   logic                  same;
   logic                  slot_open;
   logic                  higher;
   logic [POSITION_W-1:0] here;

   always_comb begin
      accept    = push & ~q_full;
      positive  = ~sample_value[SAMPLE_W-1] & (sample_value[SAMPLE_W-2:0] != '0);
      v         = sample_value[HEIGHT_W-1:0];
      v_level   = LEVEL_W'(v);
      grad      = {1'b0, v_level} - {1'b0, ref_ff};
      level_eq  = (grad == '0);
      rising    = ~grad[LEVEL_W] & ~level_eq;
      sign_now  = rising ? SIGN_POS : (level_eq ? SIGN_ZERO : SIGN_NEG);
      same      = (sign_now != SIGN_ZERO) && (sign_now == sign_ff);
      slot_open = (slot_ff != SLOT_W'(MAX_PEAKS - 1));
      higher    = (v > cur_h_ff);
      here      = POSITION_W'(index_ff);

      index_in   = index_ff;
      ref_in     = ref_ff;
      sign_in    = sign_ff;
      valley_in  = valley_ff;
      slot_in    = slot_ff;
      ovf_in     = ovf_ff;
      cur_h_in   = cur_h_ff;
      cur_pos_in = cur_pos_ff;

      push_bus                = '0;
      push_bus.peak.position  = cur_pos_ff;
      push_bus.peak.height    = cur_h_ff;

      if (positive) begin
         sign_in = sign_now;
         if (rising) begin
            if (same) begin
               if (higher) begin
                  cur_h_in   = v;
                  cur_pos_in = here;
               end
               ref_in = higher ? v_level : LEVEL_W'(cur_h_ff);
            end else begin
               ref_in = valley_ff;
               if (slot_open) begin
                  push_bus.peak_push = accept;
                  slot_in            = slot_ff + 1'b1;
                  cur_h_in           = v;
                  cur_pos_in         = here;
               end else begin
                  ovf_in = 1'b1;
                  if (higher) begin
                     cur_h_in   = v;
                     cur_pos_in = here;
                  end
               end
            end
         end else begin
            if (same) begin
               if (v_level < valley_ff) begin
                  valley_in = v_level;
               end
               ref_in = (v_level < valley_ff) ? v_level : valley_ff;
            end else begin
               ref_in    = LEVEL_W'(cur_h_ff);
               valley_in = v_level;
            end
         end
      end

      if (index_ff != SAMPLE_INDEX_W'(MAX_SAMPLES - 1)) begin
         index_in = index_ff + 1'b1;
      end

      push_bus.run_push           = accept & last_sample;
      push_bus.run.last_peak.position = cur_pos_in;
      push_bus.run.last_peak.height   = cur_h_in;
      push_bus.run.last_slot      = slot_in;
      push_bus.run.found          = (slot_in != '0) || (cur_h_in != '0);
      push_bus.run.overflow       = ovf_in;

      // The final word of a waveform leaves the tracker as after reset.
      if (last_sample) begin
         index_in  = '0;
         ref_in    = '0;
         sign_in   = SIGN_POS;
         valley_in = VALLEY_SENTINEL;
         slot_in   = '0;
         ovf_in    = 1'b0;
         cur_h_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= '0;
         ref_ff    <= '0;
         sign_ff   <= SIGN_POS;
         valley_ff <= VALLEY_SENTINEL;
         slot_ff   <= '0;
         ovf_ff    <= 1'b0;
         cur_h_ff  <= '0;
      end else if (accept) begin
         index_ff  <= index_in;
         ref_ff    <= ref_in;
         sign_ff   <= sign_in;
         valley_ff <= valley_in;
         slot_ff   <= slot_in;
         ovf_ff    <= ovf_in;
         cur_h_ff  <= cur_h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_pos_ff <= cur_pos_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/wpf_queue.sv
// Queues between front and back: closed peaks and completed waveform runs.
`default_nettype none

module wpf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  wpf_pkg::front_push_type push_bus,
   input  wpf_pkg::back_pop_type   pop_bus,
   output logic                    full,
   output wpf_pkg::queue_head_type head
);
   import wpf_pkg::*;

   peak_rec_type              peak_mem_ff [PEAK_Q_DEPTH];
   logic [PEAK_Q_PTR_W-1:0]   peak_wr_ff, peak_wr_in;
   logic [PEAK_Q_PTR_W-1:0]   peak_rd_ff, peak_rd_in;
   logic [PEAK_Q_PTR_W:0]     peak_cnt_ff, peak_cnt_in;

   run_rec_type               run_mem_ff [RUN_Q_DEPTH];
   logic [RUN_Q_PTR_W-1:0]    run_wr_ff, run_wr_in;
   logic [RUN_Q_PTR_W-1:0]    run_rd_ff, run_rd_in;
   logic [RUN_Q_PTR_W:0]      run_cnt_ff, run_cnt_in;

   always_comb begin
      peak_wr_in  = peak_wr_ff + PEAK_Q_PTR_W'(push_bus.peak_push);
      peak_rd_in  = peak_rd_ff + PEAK_Q_PTR_W'(pop_bus.peak_pop);
      peak_cnt_in = peak_cnt_ff + (PEAK_Q_PTR_W + 1)'(push_bus.peak_push)
                    - (PEAK_Q_PTR_W + 1)'(pop_bus.peak_pop);
      run_wr_in   = run_wr_ff + RUN_Q_PTR_W'(push_bus.run_push);
      run_rd_in   = run_rd_ff + RUN_Q_PTR_W'(pop_bus.run_pop);
      run_cnt_in  = run_cnt_ff + (RUN_Q_PTR_W + 1)'(push_bus.run_push)
                    - (RUN_Q_PTR_W + 1)'(pop_bus.run_pop);

      full = (peak_cnt_ff == (PEAK_Q_PTR_W + 1)'(PEAK_Q_DEPTH))
             || (run_cnt_ff == (RUN_Q_PTR_W + 1)'(RUN_Q_DEPTH));

      head.peak_valid = (peak_cnt_ff != '0);
      head.peak       = peak_mem_ff[peak_rd_ff];
      head.run_valid  = (run_cnt_ff != '0);
      head.run        = run_mem_ff[run_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_wr_ff  <= '0;
         peak_rd_ff  <= '0;
         peak_cnt_ff <= '0;
         run_wr_ff   <= '0;
         run_rd_ff   <= '0;
         run_cnt_ff  <= '0;
      end else begin
         peak_wr_ff  <= peak_wr_in;
         peak_rd_ff  <= peak_rd_in;
         peak_cnt_ff <= peak_cnt_in;
         run_wr_ff   <= run_wr_in;
         run_rd_ff   <= run_rd_in;
         run_cnt_ff  <= run_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_bus.peak_push) begin
         peak_mem_ff[peak_wr_ff] <= push_bus.peak;
      end
      if (push_bus.run_push) begin
         run_mem_ff[run_wr_ff] <= push_bus.run;
      end
   end

endmodule

`default_nettype wire

FILE: sv/wpf_back.sv
// Back end: reads finished runs from the queues and presents one result word per peak.
`default_nettype none

module wpf_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wpf_pkg::queue_head_type              head,
   output wpf_pkg::back_pop_type                pop_bus,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output logic [wpf_pkg::POSITION_W-1:0]       rsp_peak_position,
   output logic [wpf_pkg::HEIGHT_W-1:0]         rsp_peak_height,
   output logic [wpf_pkg::PEAK_NUMBER_W-1:0]    rsp_peak_number,
   output logic                                 rsp_final_peak,
   output logic                                 rsp_found_any,
   output logic                                 rsp_peaks_overflowed
);
   import wpf_pkg::*;

   typedef struct packed {
      logic [POSITION_W-1:0]    position;
      logic [HEIGHT_W-1:0]      height;
      logic [PEAK_NUMBER_W-1:0] number;
      logic                     final_peak;
      logic                     found;
      logic                     overflow;
   } rsp_rec_type;

   logic              valid_ff, valid_in;
   logic [SLOT_W-1:0] k_ff, k_in;
   rsp_rec_type       out_ff, out_in;
   logic              load;

   always_comb begin
      pop_bus  = '0;
      load     = ~valid_ff | rsp_pop;
      valid_in = valid_ff & ~rsp_pop;
      k_in     = k_ff;
      out_in   = out_ff;

      if (load && head.run_valid) begin
         if (k_ff != head.run.last_slot) begin
            if (head.peak_valid) begin
               pop_bus.peak_pop  = 1'b1;
               valid_in          = 1'b1;
               out_in.position   = head.peak.position;
               out_in.height     = head.peak.height;
               out_in.number     = PEAK_NUMBER_W'(k_ff);
               out_in.final_peak = 1'b0;
               out_in.found      = head.run.found;
               out_in.overflow   = head.run.overflow;
               k_in              = k_ff + 1'b1;
            end
         end else begin
            pop_bus.run_pop   = 1'b1;
            valid_in          = 1'b1;
            out_in.position   = head.run.found ? head.run.last_peak.position : '0;
            out_in.height     = head.run.found ? head.run.last_peak.height : '0;
            out_in.number     = PEAK_NUMBER_W'(k_ff);
            out_in.final_peak = 1'b1;
            out_in.found      = head.run.found;
            out_in.overflow   = head.run.overflow;
            k_in              = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty            = ~valid_ff;
   assign rsp_peak_position    = out_ff.position;
   assign rsp_peak_height      = out_ff.height;
   assign rsp_peak_number      = out_ff.number;
   assign rsp_final_peak       = out_ff.final_peak;
   assign rsp_found_any        = out_ff.found;
   assign rsp_peaks_overflowed = out_ff.overflow;

endmodule

`default_nettype wire

FILE: sv/waveform_peak_finder_core.sv
// Top level of the waveform peak finder: front end, queues and back end.
//
//   Channel  Handshake       Word
//   req_     push / full     sample_value, last_sample
//   rsp_     pop / empty     peak_position, peak_height, peak_number, final_peak,
//                            found_any, peaks_overflowed
//
// One sample word is taken every cycle while the queues have room.
// Results pass the queues and the output register and leave one word a cycle on pop.
// Full rises only when the closed-peak queue or the four-entry run queue is full.
// Reset clears the tracker, the queue pointers and the output valid flag.
`default_nettype none
`include "waveform_peak_finder_core_assert.svh"

module waveform_peak_finder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [wpf_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic                                 req_last_sample,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [wpf_pkg::POSITION_W-1:0]       rsp_peak_position,
   output logic [wpf_pkg::HEIGHT_W-1:0]         rsp_peak_height,
   output logic [wpf_pkg::PEAK_NUMBER_W-1:0]    rsp_peak_number,
   output logic                                 rsp_final_peak,
   output logic                                 rsp_found_any,
   output logic                                 rsp_peaks_overflowed
);
   import wpf_pkg::*;

   front_push_type push_bus;
   back_pop_type   pop_bus;
   queue_head_type head;
   logic           q_full;

   wpf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .sample_value (req_sample_value),
      .last_sample  (req_last_sample),
      .q_full       (q_full),
      .push_bus     (push_bus)
   );

   wpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_bus (push_bus),
      .pop_bus  (pop_bus),
      .full     (q_full),
      .head     (head)
   );

   wpf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop_bus              (pop_bus),
      .rsp_pop              (rsp_pop),
      .rsp_empty            (rsp_empty),
      .rsp_peak_position    (rsp_peak_position),
      .rsp_peak_height      (rsp_peak_height),
      .rsp_peak_number      (rsp_peak_number),
      .rsp_final_peak       (rsp_final_peak),
      .rsp_found_any        (rsp_found_any),
      .rsp_peaks_overflowed (rsp_peaks_overflowed)
   );

   assign req_full = q_full;

   `WPF_ASSERT_NOW(a_no_push_when_full, clock, reset,
      (push_bus.peak_push || push_bus.run_push), !q_full)
   `WPF_ASSERT_NOW(a_peak_pop_in_run, clock, reset,
      pop_bus.peak_pop, (head.peak_valid && head.run_valid && !pop_bus.run_pop))
   `WPF_ASSERT_NOW(a_empty_run_single, clock, reset,
      (!rsp_empty && !rsp_found_any),
      (rsp_final_peak && rsp_peak_number == '0 && rsp_peak_height == '0))
   `WPF_ASSERT_NEXT(a_run_queued, clock, reset,
      push_bus.run_push, head.run_valid)

endmodule

`default_nettype wire

FILE: sim/tb_waveform_peak_finder_core.sv
// Self-checking testbench for the waveform peak finder, with its own peak tracker as predictor.
`timescale 1ns / 1ps

module tb_waveform_peak_finder_core;
   import wpf_pkg::*;

   typedef enum int {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_type;
   typedef enum int {WF_NOISE, WF_SHAPED, WF_OVERFLOW} wave_kind_type;

   typedef struct packed {
      logic [15:0] level;
      logic        ends_wave;
   } sample_word_type;

   typedef struct packed {
      logic [POSITION_W-1:0]    position;
      logic [HEIGHT_W-1:0]      height;
      logic [PEAK_NUMBER_W-1:0] number;
      logic                     final_peak;
      logic                     found;
      logic                     overflowed;
   } peak_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic req_last_sample = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [POSITION_W-1:0] rsp_peak_position;
   logic [HEIGHT_W-1:0] rsp_peak_height;
   logic [PEAK_NUMBER_W-1:0] rsp_peak_number;
   logic rsp_final_peak;
   logic rsp_found_any;
   logic rsp_peaks_overflowed;

   sample_word_type pending_samples[$];
   peak_word_type expected_peaks[$];
   peak_word_type head_word;
   sample_word_type next_sample;
   phase_type phase = PH_STEADY;
   int mismatch_count = 0;

   // Tracker state of the predictor.
   int wave_index;
   int ref_level;
   logic [1:0] last_sign;
   int valley_level;
   int slot;
   logic overflowed;
   int peak_height_mem[MAX_PEAKS];
   logic [POSITION_W-1:0] peak_pos_mem[MAX_PEAKS];

   waveform_peak_finder_core u_top (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_sample_value(req_sample_value),
      .req_last_sample(req_last_sample),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_peak_position(rsp_peak_position),
      .rsp_peak_height(rsp_peak_height),
      .rsp_peak_number(rsp_peak_number),
      .rsp_final_peak(rsp_final_peak),
      .rsp_found_any(rsp_found_any),
      .rsp_peaks_overflowed(rsp_peaks_overflowed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_mismatch(input string field, input logic [15:0] got,
                                input logic [15:0] want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   function automatic void clear_tracker();
      wave_index = 0;
      ref_level = 0;
      last_sign = SIGN_POS;
      valley_level = int'(VALLEY_SENTINEL);
      slot = 0;
      overflowed = 1'b0;
      for (int k = 0; k < MAX_PEAKS; k++) begin
         peak_height_mem[k] = 0;
         peak_pos_mem[k] = '0;
      end
   endfunction

   function automatic void raise_peak(input int v);
      if (v > peak_height_mem[slot]) begin
         peak_height_mem[slot] = v;
         peak_pos_mem[slot] = POSITION_W'(wave_index);
      end
   endfunction

   function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic ends);
      int v;
      int grad;
      logic [1:0] sign;
      bit same;
      bit found;
      peak_word_type w;
      v = s;
      if (v > 0) begin
         grad = v - ref_level;
         sign = (grad > 0) ? SIGN_POS : ((grad < 0) ? SIGN_NEG : SIGN_ZERO);
         same = (sign != SIGN_ZERO) && (sign == last_sign);
         if (grad > 0) begin
            if (same) begin
               raise_peak(v);
               ref_level = peak_height_mem[slot];
            end else begin
               ref_level = valley_level;
               if (slot < MAX_PEAKS - 1) begin
                  slot++;
                  peak_height_mem[slot] = 0;
               end else begin
                  overflowed = 1'b1;
               end
               raise_peak(v);
            end
         end else if (same) begin
            if (v < valley_level)
               valley_level = v;
            ref_level = valley_level;
         end else begin
            // A fresh valley starts at the current sample, and the reference returns to the current peak's height.
            ref_level = peak_height_mem[slot];
            valley_level = v;
         end
         last_sign = sign;
      end
      if (wave_index < MAX_SAMPLES - 1)
         wave_index++;
      if (ends) begin
         found = peak_height_mem[0] != 0;
         for (int k = 0; k <= slot; k++) begin
            w.position = found ? peak_pos_mem[k] : '0;
            w.height = found ? HEIGHT_W'(peak_height_mem[k]) : '0;
            w.number = PEAK_NUMBER_W'(k);
            w.final_peak = (k == slot);
            w.found = found;
            w.overflowed = overflowed;
            expected_peaks = {expected_peaks, w};
         end
         clear_tracker();
      end
   endfunction

   function automatic void stage(input int v, input bit ends);
      sample_word_type item;
      item.level = 16'(v);
      item.ends_wave = ends;
      pending_samples = {pending_samples, item};
   endfunction

   function automatic int queue_waveform(input wave_kind_type kind);
      int len;
      int lvl;
      int prev;
      int v;
      int roll;
      case (kind)
         WF_NOISE: begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
               stage(int'($urandom), i == len - 1);
         end
         WF_SHAPED: begin
            len = $urandom_range(24, 2);
            lvl = $urandom_range(32767, 1);
            prev = lvl;
            for (int i = 0; i < len; i++) begin
               roll = $urandom_range(99);
               if (roll < 10) begin
                  v = -int'($urandom_range(32768));
               end else if (roll < 25) begin
                  v = prev;
               end else begin
                  lvl += int'($urandom_range(4000)) - 2000;
                  if (lvl < 1)
                     lvl = 1;
                  if (lvl > 32767)
                     lvl = 32767;
                  v = (roll > 96) ? 32767 : lvl;
               end
               stage(v, i == len - 1);
               prev = v;
            end
         end
         default: begin
            len = $urandom_range(44, 34);
            for (int i = 0; i < len; i++)
               stage((i % 2 == 0) ? int'($urandom_range(32767, 16384))
                                  : int'($urandom_range(16383, 1)), i == len - 1);
         end
      endcase
      return len;
   endfunction

   function automatic int idle_percent(input bit sender);
      case (phase)
         PH_SEND_IDLE: return sender ? 77 : 0;
         PH_RECV_STALL: return sender ? 0 : 77;
         PH_BOTH: return 23;
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!(req_push && req_full)) begin
         if (req_push)
            absorb_sample(req_sample_value, req_last_sample);
         if (pending_samples.size() != 0 && $urandom_range(99) >= idle_percent(1'b1)) begin
            next_sample = pending_samples.pop_front();
            req_push <= 1'b1;
            req_sample_value <= next_sample.level;
            req_last_sample <= next_sample.ends_wave;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_peaks.size() == 0) begin
               note_mismatch("word with nothing expected", 16'(rsp_peak_number), 16'd0);
            end else begin
               head_word = expected_peaks.pop_front();
               if (rsp_peak_position !== head_word.position)
                  note_mismatch("peak_position", 16'(rsp_peak_position),
                                16'(head_word.position));
               if (rsp_peak_height !== head_word.height)
                  note_mismatch("peak_height", 16'(rsp_peak_height), 16'(head_word.height));
               if (rsp_peak_number !== head_word.number)
                  note_mismatch("peak_number", 16'(rsp_peak_number), 16'(head_word.number));
               if (rsp_final_peak !== head_word.final_peak)
                  note_mismatch("final_peak", 16'(rsp_final_peak),
                                16'(head_word.final_peak));
               if (rsp_found_any !== head_word.found)
                  note_mismatch("found_any", 16'(rsp_found_any), 16'(head_word.found));
               if (rsp_peaks_overflowed !== head_word.overflowed)
                  note_mismatch("peaks_overflowed", 16'(rsp_peaks_overflowed),
                                16'(head_word.overflowed));
            end
         end
         rsp_pop <= ($urandom_range(99) >= idle_percent(1'b0));
      end
   end

   initial begin
      int staged;
      int roll;
      clear_tracker();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 4; p++) begin
         phase = phase_type'(p);
         if (phase == PH_STEADY) begin
            // Waveforms with no positive sample, with the most negative value, then a lone full-scale sample.
            stage(-32768, 1'b1);
            stage(0, 1'b0);
            stage(-1, 1'b1);
            stage(32767, 1'b1);
            // Equal samples give zero gradients; repeated maxima keep the earliest index.
            stage(5, 1'b0);
            stage(5, 1'b0);
            stage(5, 1'b0);
            stage(9, 1'b0);
            stage(9, 1'b0);
            stage(2, 1'b0);
            stage(7, 1'b1);
            stage(1, 1'b0);
            stage(32767, 1'b0);
            stage(1, 1'b0);
            stage(32767, 1'b0);
            stage(1, 1'b1);
            stage(-5, 1'b0);
            stage(3, 1'b0);
            stage(0, 1'b0);
            stage(8, 1'b1);
         end
         staged = 0;
         while (staged < 6) begin
            roll = $urandom_range(99);
            staged += queue_waveform(roll < 25 ? WF_NOISE : WF_SHAPED);
         end
         // More peaks begin here than there are slots.
         if (phase == PH_RECV_STALL)
            staged += queue_waveform(WF_OVERFLOW);
         while (pending_samples.size() != 0)
            @(posedge clock);
      end
      while (pending_samples.size() != 0 || req_push || expected_peaks.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
